>>> hdl/fcrp_pkg.sv
`default_nettype none

package fcrp_pkg;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    localparam logic [3:0] CLS_OTHER   = 4'd0;
    localparam logic [3:0] CLS_NEWLINE = 4'd1;
    localparam logic [3:0] CLS_TAB     = 4'd2;
    localparam logic [3:0] CLS_HASH    = 4'd3;
    localparam logic [3:0] CLS_GT      = 4'd4;
    localparam logic [3:0] CLS_SPACE   = 4'd5;
    localparam logic [3:0] CLS_DASH    = 4'd6;
    localparam logic [3:0] CLS_BAR     = 4'd7;
    localparam logic [3:0] CLS_LOWER   = 4'd8;
    localparam logic [3:0] CLS_UPPER   = 4'd9;
    localparam logic [3:0] CLS_EOF     = 4'd10;

    localparam logic [2:0] K_NAME  = 3'd0;
    localparam logic [2:0] K_ACC   = 3'd1;
    localparam logic [2:0] K_DONOR = 3'd2;
    localparam logic [2:0] K_SEQ   = 3'd3;
    localparam logic [2:0] K_REC   = 3'd4;
    localparam logic [2:0] K_EOF   = 3'd5;

    typedef struct packed {
        logic [3:0] cls;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic        is_query;
        logic [15:0] codon_bases;
        logic [14:0] codon_count;
        logic [15:0] codon_offset;
        logic [15:0] start_split;
        logic [15:0] end_split;
        logic [15:0] align_spaces;
        logic        last_as_query;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/fcrp_fifo.sv
`default_nettype none

module fcrp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             wr_en;
    logic             rd_en;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr_en = push & ~full;
    assign rd_en = pop & ~empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fcrp_front.sv
`default_nettype none

module fcrp_front #(
    parameter int DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [7:0]    byte_in,
    input  wire logic          end_of_file,
    output logic               item_valid,
    output fcrp_pkg::item_t    item,
    input  wire logic          item_pop
);

    fcrp_pkg::item_t                       cls_item;
    logic [$bits(fcrp_pkg::item_t)-1:0]    item_bits;
    logic                                  item_empty;

    always_comb
    begin
        cls_item.data = byte_in;
        if (end_of_file)
            cls_item.cls = fcrp_pkg::CLS_EOF;
        else if (byte_in == fcrp_pkg::CH_NEWLINE)
            cls_item.cls = fcrp_pkg::CLS_NEWLINE;
        else if (byte_in == fcrp_pkg::CH_TAB)
            cls_item.cls = fcrp_pkg::CLS_TAB;
        else if (byte_in == fcrp_pkg::CH_HASH)
            cls_item.cls = fcrp_pkg::CLS_HASH;
        else if (byte_in == fcrp_pkg::CH_GT)
            cls_item.cls = fcrp_pkg::CLS_GT;
        else if (byte_in == fcrp_pkg::CH_SPACE)
            cls_item.cls = fcrp_pkg::CLS_SPACE;
        else if (byte_in == fcrp_pkg::CH_DASH)
            cls_item.cls = fcrp_pkg::CLS_DASH;
        else if (byte_in == fcrp_pkg::CH_BAR)
            cls_item.cls = fcrp_pkg::CLS_BAR;
        else if (byte_in >= fcrp_pkg::CH_LOWER_A && byte_in <= fcrp_pkg::CH_LOWER_Z)
            cls_item.cls = fcrp_pkg::CLS_LOWER;
        else if (byte_in >= fcrp_pkg::CH_UPPER_A && byte_in <= fcrp_pkg::CH_UPPER_Z)
            cls_item.cls = fcrp_pkg::CLS_UPPER;
        else
            cls_item.cls = fcrp_pkg::CLS_OTHER;
    end

    fcrp_fifo #(
        .WIDTH ($bits(fcrp_pkg::item_t)),
        .DEPTH (DEPTH)
    ) u_item_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cls_item),
        .full    (full),
        .pop     (item_pop),
        .rd_data (item_bits),
        .empty   (item_empty)
    );

    assign item_valid = ~item_empty;
    assign item       = fcrp_pkg::item_t'(item_bits);

endmodule

`default_nettype wire

>>> hdl/fcrp_back.sv
`default_nettype none

module fcrp_back #(
    parameter int COUNTER_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire fcrp_pkg::item_t  item,
    output logic                  item_pop,
    output logic                  res_push,
    output fcrp_pkg::result_t     res,
    input  wire logic             res_full
);

    localparam int CW = COUNTER_BITS;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    localparam logic [2:0] PH_AWAIT = 3'd0;
    localparam logic [2:0] PH_NAME  = 3'd1;
    localparam logic [2:0] PH_ACC   = 3'd2;
    localparam logic [2:0] PH_DONOR = 3'd3;
    localparam logic [2:0] PH_HASH  = 3'd4;
    localparam logic [2:0] PH_SEQ   = 3'd5;
    localparam logic [2:0] PH_FULL  = 3'd6;
    localparam logic [2:0] PH_TAIL  = 3'd7;

    logic [2:0]    phase_reg,    phase_next;
    logic          queries_reg,  queries_next;
    logic          codons_reg,   codons_next;
    logic [1:0]    appended_reg, appended_next;
    logic [CW-1:0] base_reg,     base_next;
    logic [CW-1:0] quot_reg,     quot_next;
    logic [1:0]    rem_reg,      rem_next;
    logic [CW-1:0] offset_reg,   offset_next;
    logic [CW-1:0] head_reg,     head_next;
    logic [CW-1:0] tail_reg,     tail_next;
    logic [CW-1:0] space_reg,    space_next;
    logic          seen_reg,     seen_next;

    logic          consume;
    logic          emit;
    logic [CW:0]   head_sum;
    logic [CW-1:0] head_sat;
    logic [CW+15:0] base_wide;
    logic [CW+14:0] quot_wide;
    logic [CW+15:0] offset_wide;
    logic [CW+15:0] head_wide;
    logic [CW+15:0] tail_wide;
    logic [CW+15:0] space_wide;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    assign consume  = item_valid & ~res_full;
    assign item_pop = consume;
    assign res_push = consume & emit;

    assign head_sum = {1'b0, head_reg} + {1'b0, base_reg};
    assign head_sat = head_sum[CW] ? CNT_MAX : head_sum[CW-1:0];

    assign base_wide   = {16'b0, base_reg};
    assign quot_wide   = {15'b0, quot_reg};
    assign offset_wide = {16'b0, offset_reg};
    assign head_wide   = {16'b0, head_reg};
    assign tail_wide   = {16'b0, tail_reg};
    assign space_wide  = {16'b0, space_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        queries_next  = queries_reg;
        codons_next   = codons_reg;
        appended_next = appended_reg;
        base_next     = base_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        offset_next   = offset_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        space_next    = space_reg;
        seen_next     = seen_reg;
        emit          = 1'b0;
        res           = '0;
        res.data_byte = item.data;
        res.is_query  = queries_reg;

        if (item.cls == fcrp_pkg::CLS_EOF)
        begin
            emit              = 1'b1;
            res               = '0;
            res.kind          = fcrp_pkg::K_EOF;
            res.last_as_query = seen_reg & ~queries_reg;
            phase_next        = PH_AWAIT;
            queries_next      = 1'b0;
            seen_next         = 1'b0;
            codons_next       = 1'b0;
            appended_next     = '0;
            base_next         = '0;
            quot_next         = '0;
            rem_next          = '0;
            offset_next       = '0;
            head_next         = '0;
            tail_next         = '0;
            space_next        = '0;
        end
        else if ((item.cls == fcrp_pkg::CLS_NEWLINE)
                 && (phase_reg == PH_SEQ || phase_reg == PH_FULL || phase_reg == PH_TAIL))
        begin
            emit              = 1'b1;
            res.kind          = fcrp_pkg::K_REC;
            res.data_byte     = '0;
            res.codon_bases   = base_wide[15:0];
            res.codon_count   = queries_reg ? 15'd0 : quot_wide[14:0];
            res.codon_offset  = offset_wide[15:0];
            res.start_split   = head_wide[15:0];
            res.end_split     = tail_wide[15:0];
            res.align_spaces  = space_wide[15:0];
            seen_next         = seen_reg | ~queries_reg;
            phase_next        = PH_AWAIT;
            codons_next       = 1'b0;
            appended_next     = '0;
            base_next         = '0;
            quot_next         = '0;
            rem_next          = '0;
            offset_next       = '0;
            head_next         = '0;
            tail_next         = '0;
            space_next        = '0;
        end
        else
        begin
            case (phase_reg)
                PH_AWAIT:
                begin
                    if (item.cls == fcrp_pkg::CLS_HASH)
                    begin
                        queries_next = 1'b1;
                        phase_next   = PH_HASH;
                    end
                    else if (item.cls == fcrp_pkg::CLS_GT)
                    begin
                        phase_next = PH_NAME;
                    end
                end
                PH_NAME:
                begin
                    if (item.cls == fcrp_pkg::CLS_TAB)
                        phase_next = PH_ACC;
                    else if (item.cls == fcrp_pkg::CLS_NEWLINE)
                        phase_next = PH_SEQ;
                    else
                    begin
                        emit     = 1'b1;
                        res.kind = fcrp_pkg::K_NAME;
                    end
                end
                PH_ACC:
                begin
                    if (item.cls == fcrp_pkg::CLS_TAB)
                        phase_next = PH_DONOR;
                    else
                    begin
                        emit     = 1'b1;
                        res.kind = fcrp_pkg::K_ACC;
                    end
                end
                PH_DONOR:
                begin
                    if (item.cls == fcrp_pkg::CLS_NEWLINE)
                        phase_next = PH_SEQ;
                    else
                    begin
                        emit     = 1'b1;
                        res.kind = fcrp_pkg::K_DONOR;
                    end
                end
                PH_HASH:
                begin
                    if (item.cls == fcrp_pkg::CLS_NEWLINE)
                        phase_next = PH_AWAIT;
                end
                PH_SEQ:
                begin
                    if (item.cls == fcrp_pkg::CLS_SPACE)
                        space_next = sat_inc(space_reg);
                    else if (item.cls == fcrp_pkg::CLS_BAR)
                    begin
                        head_next   = head_sat;
                        offset_next = head_sat;
                        tail_next   = '0;
                        base_next   = '0;
                        quot_next   = '0;
                        rem_next    = '0;
                        codons_next = 1'b0;
                        phase_next  = PH_FULL;
                    end
                    else if (item.cls != fcrp_pkg::CLS_DASH)
                    begin
                        emit     = 1'b1;
                        res.kind = fcrp_pkg::K_SEQ;
                        if (appended_reg != 2'd2)
                            appended_next = appended_reg + 1'b1;
                        if (item.cls == fcrp_pkg::CLS_LOWER)
                        begin
                            if (!codons_reg)
                                offset_next = sat_inc(offset_reg);
                            if (appended_reg != 2'd2)
                                head_next = sat_inc(head_reg);
                            else
                                tail_next = sat_inc(tail_reg);
                        end
                        else if (item.cls == fcrp_pkg::CLS_UPPER)
                        begin
                            codons_next = 1'b1;
                            if (base_reg != CNT_MAX)
                            begin
                                base_next = base_reg + 1'b1;
                                if (rem_reg == 2'd2)
                                begin
                                    rem_next  = '0;
                                    quot_next = quot_reg + 1'b1;
                                end
                                else
                                    rem_next = rem_reg + 1'b1;
                            end
                        end
                    end
                end
                PH_FULL:
                begin
                    if (item.cls == fcrp_pkg::CLS_BAR)
                        phase_next = PH_TAIL;
                    else if (item.cls != fcrp_pkg::CLS_DASH)
                    begin
                        emit        = 1'b1;
                        res.kind    = fcrp_pkg::K_SEQ;
                        codons_next = 1'b1;
                        if (appended_reg != 2'd2)
                            appended_next = appended_reg + 1'b1;
                        if (base_reg != CNT_MAX)
                        begin
                            base_next = base_reg + 1'b1;
                            if (rem_reg == 2'd2)
                            begin
                                rem_next  = '0;
                                quot_next = quot_reg + 1'b1;
                            end
                            else
                                rem_next = rem_reg + 1'b1;
                        end
                    end
                end
                PH_TAIL:
                begin
                    if (item.cls != fcrp_pkg::CLS_DASH)
                    begin
                        emit      = 1'b1;
                        res.kind  = fcrp_pkg::K_SEQ;
                        tail_next = sat_inc(tail_reg);
                        if (appended_reg != 2'd2)
                            appended_next = appended_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_AWAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_AWAIT;
            queries_reg  <= 1'b0;
            codons_reg   <= 1'b0;
            appended_reg <= '0;
            base_reg     <= '0;
            quot_reg     <= '0;
            rem_reg      <= '0;
            offset_reg   <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            space_reg    <= '0;
            seen_reg     <= 1'b0;
        end
        else if (consume)
        begin
            phase_reg    <= phase_next;
            queries_reg  <= queries_next;
            codons_reg   <= codons_next;
            appended_reg <= appended_next;
            base_reg     <= base_next;
            quot_reg     <= quot_next;
            rem_reg      <= rem_next;
            offset_reg   <= offset_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            space_reg    <= space_next;
            seen_reg     <= seen_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fasta_codon_record_parser.sv
// A result is queued in the same cycle that the parse unit consumes its item.
// Throughput: one item per cycle while the result queue is not full; each item
// updates the phase and counters; a running remainder keeps the codon quotient.
// Input and result queues decouple both sides; each holds QUEUE_DEPTH items.
// Reset (rst_n low) empties both queues and returns the parser to record start.
`default_nettype none

module fasta_codon_record_parser #(
    parameter int COUNTER_BITS = 16,
    parameter int QUEUE_DEPTH  = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  byte_in,
    input  wire logic        end_of_file,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       kind,
    output logic [7:0]       data_byte,
    output logic             is_query,
    output logic [15:0]      codon_bases,
    output logic [14:0]      codon_count,
    output logic [15:0]      codon_offset,
    output logic [15:0]      start_split,
    output logic [15:0]      end_split,
    output logic [15:0]      align_spaces,
    output logic             last_as_query
);

    fcrp_pkg::item_t                        item;
    logic                                   item_valid;
    logic                                   item_pop;
    fcrp_pkg::result_t                      res_in;
    fcrp_pkg::result_t                      res_out;
    logic [$bits(fcrp_pkg::result_t)-1:0]   res_bits;
    logic                                   res_push;
    logic                                   res_full;

    fcrp_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .byte_in     (byte_in),
        .end_of_file (end_of_file),
        .item_valid  (item_valid),
        .item        (item),
        .item_pop    (item_pop)
    );

    fcrp_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_push   (res_push),
        .res        (res_in),
        .res_full   (res_full)
    );

    fcrp_fifo #(
        .WIDTH ($bits(fcrp_pkg::result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_bits),
        .empty   (empty)
    );

    assign res_out       = fcrp_pkg::result_t'(res_bits);
    assign kind          = res_out.kind;
    assign data_byte     = res_out.data_byte;
    assign is_query      = res_out.is_query;
    assign codon_bases   = res_out.codon_bases;
    assign codon_count   = res_out.codon_count;
    assign codon_offset  = res_out.codon_offset;
    assign start_split   = res_out.start_split;
    assign end_split     = res_out.end_split;
    assign align_spaces  = res_out.align_spaces;
    assign last_as_query = res_out.last_as_query;

    a_no_result_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full
    ) else $error("result written into a full queue");

    a_pop_needs_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        item_pop |-> item_valid
    ) else $error("parser consumed from an empty item queue");

    a_summary_only_at_record_end: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && kind != fcrp_pkg::K_REC) |->
            (codon_bases == '0 && codon_count == '0 && codon_offset == '0
             && start_split == '0 && end_split == '0 && align_spaces == '0)
    ) else $error("record counters on a non-summary result");

    a_last_query_at_file_end: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && last_as_query) |-> (kind == fcrp_pkg::K_EOF && !is_query)
    ) else $error("last-as-query flag outside file end");

endmodule

`default_nettype wire

>>> tb/tb.sv
module tb;

    typedef enum logic [2:0] {
        AWAIT_REC,
        IN_NAME,
        IN_ACCEPTOR,
        IN_DONOR,
        IN_HASH_LINE,
        IN_SEQ_HEAD,
        IN_SEQ_FULL,
        IN_SEQ_TAIL
    } parse_phase_e;

    class codon_record_tracker;
        parse_phase_e        phase;
        bit                  queries;
        bit                  codons;
        bit                  seen;
        logic [1:0]          appended;
        logic [15:0]         bases;
        logic [15:0]         offset;
        logic [15:0]         head_split;
        logic [15:0]         tail_split;
        logic [15:0]         spaces;
        fcrp_pkg::result_t   pending_results[$];
        int                  faults;

        function new();
            faults = 0;
            restart();
        endfunction

        function void clear_counts();
            codons = 1'b0;
            appended = 2'd0;
            bases = 16'd0;
            offset = 16'd0;
            head_split = 16'd0;
            tail_split = 16'd0;
            spaces = 16'd0;
        endfunction

        function void restart();
            phase = AWAIT_REC;
            queries = 1'b0;
            seen = 1'b0;
            clear_counts();
        endfunction

        function logic [15:0] bump(logic [15:0] a, logic [15:0] b);
            logic [16:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[16] ? 16'hFFFF : s[15:0];
        endfunction

        function void emit_byte(logic [2:0] k, logic [7:0] c);
            fcrp_pkg::result_t r;
            r = '0;
            r.kind = k;
            r.data_byte = c;
            r.is_query = queries;
            pending_results.push_back(r);
        endfunction

        function void emit_seq(logic [7:0] c);
            if (appended < 2'd2)
                appended++;
            emit_byte(fcrp_pkg::K_SEQ, c);
        endfunction

        function void close_record();
            fcrp_pkg::result_t r;
            r = '0;
            r.kind = fcrp_pkg::K_REC;
            r.is_query = queries;
            r.codon_bases = bases;
            r.codon_count = queries ? 15'd0 : 15'(bases / 16'd3);
            r.codon_offset = offset;
            r.start_split = head_split;
            r.end_split = tail_split;
            r.align_spaces = spaces;
            pending_results.push_back(r);
            if (!queries)
                seen = 1'b1;
            clear_counts();
            phase = AWAIT_REC;
        endfunction

        function void note_item(logic [7:0] c, logic eof);
            fcrp_pkg::result_t r;
            if (eof)
            begin
                r = '0;
                r.kind = fcrp_pkg::K_EOF;
                r.last_as_query = seen && !queries;
                pending_results.push_back(r);
                restart();
                return;
            end
            case (phase)
                AWAIT_REC:
                begin
                    if (c == fcrp_pkg::CH_HASH)
                    begin
                        queries = 1'b1;
                        phase = IN_HASH_LINE;
                    end
                    else if (c == fcrp_pkg::CH_GT)
                        phase = IN_NAME;
                end
                IN_NAME:
                begin
                    if (c == fcrp_pkg::CH_TAB)
                        phase = IN_ACCEPTOR;
                    else if (c == fcrp_pkg::CH_NEWLINE)
                        phase = IN_SEQ_HEAD;
                    else
                        emit_byte(fcrp_pkg::K_NAME, c);
                end
                IN_ACCEPTOR:
                begin
                    if (c == fcrp_pkg::CH_TAB)
                        phase = IN_DONOR;
                    else
                        emit_byte(fcrp_pkg::K_ACC, c);
                end
                IN_DONOR:
                begin
                    if (c == fcrp_pkg::CH_NEWLINE)
                        phase = IN_SEQ_HEAD;
                    else
                        emit_byte(fcrp_pkg::K_DONOR, c);
                end
                IN_HASH_LINE:
                begin
                    if (c == fcrp_pkg::CH_NEWLINE)
                        phase = AWAIT_REC;
                end
                IN_SEQ_HEAD:
                begin
                    if (c == fcrp_pkg::CH_NEWLINE)
                        close_record();
                    else if (c == fcrp_pkg::CH_SPACE)
                        spaces = bump(spaces, 16'd1);
                    else if (c == fcrp_pkg::CH_BAR)
                    begin
                        head_split = bump(head_split, bases);
                        offset = head_split;
                        tail_split = 16'd0;
                        bases = 16'd0;
                        codons = 1'b0;
                        phase = IN_SEQ_FULL;
                    end
                    else if (c != fcrp_pkg::CH_DASH)
                    begin
                        if (c >= fcrp_pkg::CH_LOWER_A && c <= fcrp_pkg::CH_LOWER_Z)
                        begin
                            if (!codons)
                                offset = bump(offset, 16'd1);
                            if (appended < 2'd2)
                                head_split = bump(head_split, 16'd1);
                            else
                                tail_split = bump(tail_split, 16'd1);
                        end
                        else if (c >= fcrp_pkg::CH_UPPER_A && c <= fcrp_pkg::CH_UPPER_Z)
                        begin
                            codons = 1'b1;
                            bases = bump(bases, 16'd1);
                        end
                        emit_seq(c);
                    end
                end
                IN_SEQ_FULL:
                begin
                    if (c == fcrp_pkg::CH_NEWLINE)
                        close_record();
                    else if (c == fcrp_pkg::CH_BAR)
                        phase = IN_SEQ_TAIL;
                    else if (c != fcrp_pkg::CH_DASH)
                    begin
                        codons = 1'b1;
                        bases = bump(bases, 16'd1);
                        emit_seq(c);
                    end
                end
                default:
                begin
                    if (c == fcrp_pkg::CH_NEWLINE)
                        close_record();
                    else if (c != fcrp_pkg::CH_DASH)
                    begin
                        tail_split = bump(tail_split, 16'd1);
                        emit_seq(c);
                    end
                end
            endcase
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report_mismatch(string line);
            $display("mismatch: %s", line);
            faults++;
        endtask

        task match_field(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
        endtask

        task check_result(fcrp_pkg::result_t got);
            fcrp_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result of kind %0d", got.kind));
                return;
            end
            want = pending_results.pop_front();
            match_field("kind", 16'(got.kind), 16'(want.kind));
            match_field("data_byte", 16'(got.data_byte), 16'(want.data_byte));
            match_field("is_query", 16'(got.is_query), 16'(want.is_query));
            match_field("codon_bases", got.codon_bases, want.codon_bases);
            match_field("codon_count", 16'(got.codon_count), 16'(want.codon_count));
            match_field("codon_offset", got.codon_offset, want.codon_offset);
            match_field("start_split", got.start_split, want.start_split);
            match_field("end_split", got.end_split, want.end_split);
            match_field("align_spaces", got.align_spaces, want.align_spaces);
            match_field("last_as_query", 16'(got.last_as_query),
                        16'(want.last_as_query));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  byte_in;
    logic        end_of_file;
    logic        empty;
    logic        pop;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        is_query;
    logic [15:0] codon_bases;
    logic [14:0] codon_count;
    logic [15:0] codon_offset;
    logic [15:0] start_split;
    logic [15:0] end_split;
    logic [15:0] align_spaces;
    logic        last_as_query;

    codon_record_tracker ledger;
    bit                  steady;
    int                  sent;

    fasta_codon_record_parser DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .byte_in(byte_in),
        .end_of_file(end_of_file),
        .empty(empty),
        .pop(pop),
        .kind(kind),
        .data_byte(data_byte),
        .is_query(is_query),
        .codon_bases(codon_bases),
        .codon_count(codon_count),
        .codon_offset(codon_offset),
        .start_split(start_split),
        .end_split(end_split),
        .align_spaces(align_spaces),
        .last_as_query(last_as_query)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] pick_letter(bit lower);
        logic [7:0] first;
        first = lower ? fcrp_pkg::CH_LOWER_A : fcrp_pkg::CH_UPPER_A;
        return first + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] seq_byte();
        case ($urandom_range(0, 9))
            0: return fcrp_pkg::CH_SPACE;
            1: return fcrp_pkg::CH_DASH;
            2: return pick_letter(1'b1);
            3: return 8'($urandom_range(0, 255));
            default: return pick_letter(1'b0);
        endcase
    endfunction

    task automatic send_item(input logic [7:0] c, input logic eof);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        byte_in <= c;
        end_of_file <= eof;
        @(posedge clk);
        while (full)
            @(posedge clk);
        ledger.note_item(c, eof);
        sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic hold_off();
        @(negedge clk);
        push <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_record();
        int n;
        int m;
        send_text(">");
        n = $urandom_range(1, 4);
        repeat (n)
            send_item(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : pick_letter(1'($urandom_range(0, 1))),
                      1'b0);
        if ($urandom_range(0, 1))
        begin
            send_text("\t");
            n = $urandom_range(0, 3);
            repeat (n)
                send_item(($urandom_range(0, 4) == 0) ? fcrp_pkg::CH_NEWLINE
                                                      : pick_letter(1'($urandom_range(0, 1))),
                          1'b0);
            send_text("\t");
            n = $urandom_range(0, 3);
            repeat (n)
                send_item(pick_letter(1'($urandom_range(0, 1))), 1'b0);
        end
        send_text("\n");
        n = $urandom_range(0, 3);
        repeat (n)
            send_item(pick_letter(1'b1), 1'b0);
        n = $urandom_range(0, 12);
        repeat (n)
            send_item(seq_byte(), 1'b0);
        n = $urandom_range(0, 3);
        repeat (n)
        begin
            send_text("|");
            m = $urandom_range(0, 6);
            repeat (m)
                send_item(seq_byte(), 1'b0);
        end
        send_text("\n");
    endtask

    initial
    begin
        int n;
        ledger = new();
        rst_n = 1'b0;
        push = 1'b0;
        byte_in = 8'd0;
        end_of_file = 1'b0;
        steady = 1'b0;
        sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_text("x>");
        send_item(8'hFF, 1'b0);
        send_text("\tb\nc\td\naA");
        send_item(8'h00, 1'b0);
        send_text(" -|C|g|\n#\n>q");
        send_item(8'hFF, 1'b1);
        hold_off();

        while (sent < 790)
        begin
            steady = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 11))
                0:
                begin
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send_item(8'($urandom_range(0, 255)), 1'b0);
                end
                1:
                begin
                    send_text("#");
                    n = $urandom_range(0, 4);
                    repeat (n)
                        send_item(pick_letter(1'($urandom_range(0, 1))), 1'b0);
                    send_text("\n");
                end
                2: send_item(8'($urandom_range(0, 255)), 1'b1);
                3:
                begin
                    send_text(">");
                    n = $urandom_range(0, 5);
                    repeat (n)
                        send_item(seq_byte(), 1'b0);
                    send_item(8'($urandom_range(0, 255)), 1'b1);
                end
                4: hold_off();
                default: send_record();
            endcase
        end
        steady = 1'b0;
        send_item(8'h00, 1'b1);

        hold_off();
        repeat (8) @(posedge clk);
        if (ledger.faults == 0)
            $display("fasta_codon_record_parser regression: pass");
        else
            $display("fasta_codon_record_parser regression: fail");
        $finish;
    end

    initial
    begin : drain
        int                stall;
        fcrp_pkg::result_t got;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 3);
            @(negedge clk);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            got.kind = kind;
            got.data_byte = data_byte;
            got.is_query = is_query;
            got.codon_bases = codon_bases;
            got.codon_count = codon_count;
            got.codon_offset = codon_offset;
            got.start_split = start_split;
            got.end_split = end_split;
            got.align_spaces = align_spaces;
            got.last_as_query = last_as_query;
            ledger.check_result(got);
        end
    end

    initial
    begin
        #2000000;
        $display("fasta_codon_record_parser regression: fail");
        $finish;
    end
endmodule

>>> fasta_codon_record_parser.f
hdl/fcrp_pkg.sv
hdl/fcrp_fifo.sv
hdl/fcrp_front.sv
hdl/fcrp_back.sv
hdl/fasta_codon_record_parser.sv
tb/tb.sv
